// ===== sv/wrf_pkg.sv =====
`timescale 1ns / 1ps
package wrf_pkg;

    localparam int PIX_W   = 8;
    localparam int CFG_W   = 11;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WSIZE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd3;

    localparam logic [1:0] MODE_MIN = 2'd0;
    localparam logic [1:0] MODE_MAX = 2'd1;
    localparam logic [1:0] MODE_MED = 2'd2;

    localparam logic FUNC_FLUSH = 1'b1;

    typedef struct packed {
        logic             func;
        logic [PIX_W-1:0] pixel;
    } t_in;

    typedef struct packed {
        logic [PIX_W-1:0] out_pixel;
        logic             out_last;
    } t_out;

    // link between neighboring sort cells
    typedef struct packed {
        logic             take;
        logic             valid;
        logic [PIX_W-1:0] val;
    } t_link;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GATHER,
        ST_DRAIN,
        ST_EMIT
    } t_state;

endpackage

// ===== sv/window_rank_filter_unit.sv =====
`timescale 1ns / 1ps
// an item that completes a window starts a walk over the (2*h+1) squared window pixels
// (h = window half-size), one window pixel per cycle, then a drain and an emit state that
// registers the result; no new item is taken until the result is registered, longer while
// an earlier result is still stalled; other items one per cycle while no walk or write is pending
// reset: synchronous active low, registers to mode median, size 3, 1024 x 1024, frame
// positions to zero, input held off in the cycle after reset and after a register write
module window_rank_filter_unit
    import wrf_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_WINDOW = 7
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in                  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out                 o_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    // line store holds MAX_WINDOW - 1 rows of MAX_WIDTH plus MAX_WINDOW pixels
    localparam int LINE_DEPTH = (MAX_WINDOW - 1) * MAX_WIDTH + MAX_WINDOW;
    localparam int AW         = $clog2(LINE_DEPTH);
    localparam int NCELLS     = MAX_WINDOW * MAX_WINDOW;
    localparam int IW         = $clog2(NCELLS);
    localparam int CW         = $clog2(NCELLS + 1);
    localparam int HALF_MAX   = MAX_WINDOW / 2;
    localparam int OFF_W      = 4;
    localparam int POS_W      = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_WIDTH * MAX_WINDOW) + 1;

    function automatic logic [AW-1:0] add_wrap(input logic [AW-1:0] a, input logic [AW-1:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (AW+1)'(LINE_DEPTH)) begin
            s = s - (AW+1)'(LINE_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] sub_wrap(input logic [AW-1:0] a, input logic [AW-1:0] b);
        logic [AW:0] s;
        if (a >= b) begin
            s = {1'b0, a} - {1'b0, b};
        end else begin
            s = {1'b0, a} + (AW+1)'(LINE_DEPTH) - {1'b0, b};
        end
        return s[AW-1:0];
    endfunction

    // configuration registers, raw as written
    logic [1:0]       r_mode;
    logic [2:0]       r_wsize;
    logic [CFG_W-1:0] r_cfg_w;
    logic [CFG_W-1:0] r_cfg_h;
    logic             r_cfg_pend;

    // derived geometry, registered once per cycle
    logic [CFG_W-1:0] eff_w, eff_h, r_w, r_h;
    logic [1:0]       eff_half, r_half;
    logic [POS_W-1:0] r_tot, r_dly;

    // frame tracking
    logic [POS_W-1:0] r_inpos, r_outpos;
    logic [CFG_W-1:0] r_cx, r_cy;
    logic [AW-1:0]    r_wr_addr, r_cen_addr;

    // window walk
    t_state           r_state, n_state;
    logic [OFF_W-1:0] r_gx, r_gy, twoh;
    logic [AW-1:0]    r_row_addr, r_col_addr;
    logic             r_ins;
    logic [CW-1:0]    r_cnt;

    logic             r_out_vld;
    t_out             r_out;

    logic             in_acc, out_acc, below, take, start, geo_wr;
    logic [POS_W-1:0] inpos_n;
    logic             in_x, in_y, walk_end, row_end, emit, last;
    logic [CFG_W+1:0] sx, sy;
    logic [PIX_W-1:0] rd_data, sel;
    logic [IW-1:0]    idx;

    // ---------------- configuration ----------------
    assign geo_wr = i_cfg_we && (i_cfg_idx != CFG_MODE);

    // pending flag also covers the first cycle after reset, while geometry settles
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_MED;
            r_wsize    <= 3'd3;
            r_cfg_w    <= 11'd1024;
            r_cfg_h    <= 11'd1024;
            r_cfg_pend <= 1'b1;
        end else begin
            r_cfg_pend <= i_cfg_we;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MODE:   r_mode  <= i_cfg_data[1:0];
                    CFG_WSIZE:  r_wsize <= i_cfg_data[2:0];
                    CFG_WIDTH:  r_cfg_w <= i_cfg_data;
                    CFG_HEIGHT: r_cfg_h <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // clamp sizes to the supported range
    always_comb begin
        eff_w = r_cfg_w;
        if (r_cfg_w == '0) begin
            eff_w = CFG_W'(1);
        end else if (32'(r_cfg_w) > MAX_WIDTH) begin
            eff_w = CFG_W'(MAX_WIDTH);
        end
        eff_h = r_cfg_h;
        if (r_cfg_h == '0) begin
            eff_h = CFG_W'(1);
        end else if (32'(r_cfg_h) > MAX_HEIGHT) begin
            eff_h = CFG_W'(MAX_HEIGHT);
        end
        eff_half = r_wsize[2:1];
        if (32'(eff_half) > HALF_MAX) begin
            eff_half = 2'(HALF_MAX);
        end
    end

    always_ff @(posedge i_clk) begin
        r_w    <= eff_w;
        r_h    <= eff_h;
        r_half <= eff_half;
        r_tot  <= POS_W'(eff_w * eff_h);
        r_dly  <= POS_W'(eff_half * eff_w + CFG_W'(eff_half));
    end

    // ---------------- input side ----------------
    assign o_in_stall = (r_state != ST_IDLE) || r_cfg_pend;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_acc    = r_out_vld && !i_out_stall;
    assign below      = r_inpos < r_tot;
    // early flush is dropped, surplus pixels count as flush ticks
    assign take       = !below || (i_in_data.func != FUNC_FLUSH);
    assign inpos_n    = r_inpos + POS_W'(1);
    assign start      = in_acc && take && (inpos_n > r_outpos + r_dly) && (r_outpos < r_tot);

    wrf_ram #(
        .WIDTH(PIX_W),
        .DEPTH(LINE_DEPTH)
    ) u_line (
        .i_clk  (i_clk),
        .i_we   (in_acc && below && (i_in_data.func != FUNC_FLUSH)),
        .i_waddr(r_wr_addr),
        .i_wdata(i_in_data.pixel),
        .i_raddr(r_col_addr),
        .o_rdata(rd_data)
    );

    // ---------------- window walk ----------------
    assign twoh     = OFF_W'({r_half, 1'b0});
    assign row_end  = (r_gx == twoh);
    assign walk_end = row_end && (r_gy == twoh);
    assign sx       = (CFG_W+2)'(r_cx) + (CFG_W+2)'(r_gx);
    assign sy       = (CFG_W+2)'(r_cy) + (CFG_W+2)'(r_gy);
    // window pixel inside the image
    assign in_x     = (sx >= (CFG_W+2)'(r_half)) && (sx < (CFG_W+2)'(r_w) + (CFG_W+2)'(r_half));
    assign in_y     = (sy >= (CFG_W+2)'(r_half)) && (sy < (CFG_W+2)'(r_h) + (CFG_W+2)'(r_half));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (start) n_state = ST_GATHER;
            ST_GATHER: if (walk_end) n_state = ST_DRAIN;
            ST_DRAIN:  n_state = ST_EMIT;
            ST_EMIT:   if (!r_out_vld) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        emit = (r_state == ST_EMIT) && !r_out_vld;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ins <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_ins <= (r_state == ST_GATHER) && in_x && in_y;
            if (start) begin
                r_cnt <= '0;
            end else if (r_ins) begin
                r_cnt <= r_cnt + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_gx       <= '0;
            r_gy       <= '0;
            r_row_addr <= sub_wrap(r_cen_addr, AW'(r_dly));
            r_col_addr <= sub_wrap(r_cen_addr, AW'(r_dly));
        end else if (r_state == ST_GATHER) begin
            if (row_end) begin
                r_gx       <= '0;
                r_gy       <= r_gy + OFF_W'(1);
                r_row_addr <= add_wrap(r_row_addr, AW'(r_w));
                r_col_addr <= add_wrap(r_row_addr, AW'(r_w));
            end else begin
                r_gx       <= r_gx + OFF_W'(1);
                r_col_addr <= add_wrap(r_col_addr, AW'(1));
            end
        end
    end

    // sort chain; minimum, median or maximum picked by rank
    always_comb begin
        if (r_mode == MODE_MIN) begin
            idx = '0;
        end else if (r_mode == MODE_MAX) begin
            idx = IW'(r_cnt - CW'(1));
        end else begin
            idx = IW'(r_cnt >> 1);
        end
    end

    wrf_sorter #(
        .NCELLS(NCELLS)
    ) u_sort (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_clr  (start),
        .i_ins  (r_ins),
        .i_x    (rd_data),
        .i_idx  (idx),
        .o_sel  (sel)
    );

    // ---------------- positions ----------------
    assign last = (r_outpos + POS_W'(1)) == r_tot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || geo_wr) begin
            r_inpos    <= '0;
            r_outpos   <= '0;
            r_cx       <= '0;
            r_cy       <= '0;
            r_wr_addr  <= '0;
            r_cen_addr <= '0;
        end else if (emit && last) begin
            // frame done, next pixel starts a new frame
            r_inpos    <= '0;
            r_outpos   <= '0;
            r_cx       <= '0;
            r_cy       <= '0;
            r_wr_addr  <= '0;
            r_cen_addr <= '0;
        end else begin
            if (in_acc && take) begin
                r_inpos <= inpos_n;
            end
            if (in_acc && below && (i_in_data.func != FUNC_FLUSH)) begin
                r_wr_addr <= add_wrap(r_wr_addr, AW'(1));
            end
            if (emit) begin
                r_outpos   <= r_outpos + POS_W'(1);
                r_cen_addr <= add_wrap(r_cen_addr, AW'(1));
                if (r_cx == r_w - CFG_W'(1)) begin
                    r_cx <= '0;
                    r_cy <= r_cy + CFG_W'(1);
                end else begin
                    r_cx <= r_cx + CFG_W'(1);
                end
            end
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (emit) begin
            r_out_vld <= 1'b1;
        end else if (out_acc) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= '{out_pixel: sel, out_last: last};
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

// ===== sv/wrf_ram.sv =====
`timescale 1ns / 1ps
module wrf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/wrf_cell.sv =====
`timescale 1ns / 1ps
module wrf_cell
    import wrf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_clr,
    input  logic             i_ins,
    input  logic [PIX_W-1:0] i_x,
    input  t_link            i_prev,
    output t_link            o_link
);

    logic             r_valid;
    logic [PIX_W-1:0] r_val;
    logic             take;

    // new value belongs here or further left
    assign take = !r_valid || (i_x < r_val);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_valid <= 1'b0;
        end else if (i_ins) begin
            if (i_prev.take) begin
                r_valid <= i_prev.valid;
            end else if (take) begin
                r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ins) begin
            if (i_prev.take) begin
                r_val <= i_prev.val;
            end else if (take) begin
                r_val <= i_x;
            end
        end
    end

    assign o_link = '{take: take, valid: r_valid, val: r_val};

endmodule

// ===== sv/wrf_sorter.sv =====
`timescale 1ns / 1ps
module wrf_sorter
    import wrf_pkg::*;
#(
    parameter int NCELLS = 49
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_clr,
    input  logic                      i_ins,
    input  logic [PIX_W-1:0]          i_x,
    input  logic [$clog2(NCELLS)-1:0] i_idx,
    output logic [PIX_W-1:0]          o_sel
);

    t_link links [NCELLS];
    logic [PIX_W-1:0] vals [NCELLS];

    for (genvar g = 0; g < NCELLS; g++) begin : g_cell
        t_link prev;
        if (g == 0) begin : g_first
            assign prev = '0;
        end else begin : g_rest
            assign prev = links[g-1];
        end
        wrf_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_clr  (i_clr),
            .i_ins  (i_ins),
            .i_x    (i_x),
            .i_prev (prev),
            .o_link (links[g])
        );
        assign vals[g] = links[g].val;
    end

    assign o_sel = vals[i_idx];

endmodule

// ===== sv/wrf_checker.sv =====
`timescale 1ns / 1ps
module wrf_checker
    import wrf_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_in_stall,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input t_out                 o_out_data,
    input logic                 i_cfg_we
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // reset empties the output
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a register write holds off input in the cycle after it
    a_cfg_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> o_in_stall)
        else $error("input taken right after register write");

    // results never come in consecutive cycles
    a_out_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall |=> !o_out_valid)
        else $error("back to back results");

endmodule

bind window_rank_filter_unit wrf_checker u_chk (.*);
